// ----- hw/rtl/plist_pkg.sv -----
// shared types and constants for the positional list store
// request and status codes, store control struct; no dependencies
package plist_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int REQ_W           = 3;
    localparam int DATA_W          = 32;
    localparam int POS_W           = 8;
    localparam int STATUS_W        = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_DUMP      = 3'd6
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // store update command
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } store_ctl_t;

endpackage

// ----- hw/rtl/plist_store.sv -----
// shifting register array that holds the list entries, front at index 0
// depends on plist_pkg for the control struct
module plist_store
    import plist_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  store_ctl_t                        ctl,
    input  logic [IDX_W-1:0]                  idx,
    input  logic [VALUE_WIDTH-1:0]            wr_value,
    output logic [DEPTH-1:0][VALUE_WIDTH-1:0] entries
);

    logic [DEPTH-1:0][VALUE_WIDTH-1:0] entry_reg;
    logic [DEPTH-1:0][VALUE_WIDTH-1:0] entry_next;

    // each entry picks from itself, a neighbor or the new value
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
            if (ctl.ins_en) begin
                if (IDX_W'(i) == idx) begin
                    entry_next[i] = wr_value;
                end else if (IDX_W'(i) > idx && i > 0) begin
                    entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (ctl.del_en) begin
                if (IDX_W'(i) >= idx && i < DEPTH - 1) begin
                    entry_next[i] = entry_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entries = entry_reg;

endmodule

// ----- hw/rtl/positional_list_store_top.sv -----
// positional list store: bounded ordered list with insert, delete and dump
// depends on plist_pkg and plist_store
//
// Ordered list of up to DEPTH signed values addressed by 1-based position, kept in a
// register array that shifts as a whole. Every insert or delete request gives one
// result beat marked last, so with m_ready held high a request is taken every cycle.
// A dump gives one beat per element, front first, and blocks the input channel until
// its final beat has been loaded into the output register. A dump of an empty list
// gives one beat with item_valid low. Bad positions, deletes from an empty list
// and unknown request codes return status ignored; inserts into a full list return
// status full; the list is unchanged in both cases. Every beat carries the element
// count after the request. The output is a single register stage; s_ready depends
// on m_ready combinationally.
module positional_list_store_top
    import plist_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int IDX_W      = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [POS_W-1:0]    s_position,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [CNT_W-1:0]    m_element_count,
    output logic signed [DATA_W-1:0] m_item_value,
    output logic                m_item_valid,
    output logic                m_last
);

    localparam int EXT_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int CMP_W = POS_W + 1;

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dump_busy_reg, dump_busy_next;
    logic [IDX_W-1:0] dump_idx_reg, dump_idx_next;
    logic             m_valid_reg, m_valid_next;

    // output payload
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [CNT_W-1:0]        ocount_reg, ocount_next;
    logic signed [DATA_W-1:0] ovalue_reg, ovalue_next;
    logic                    ovalid_reg, ovalid_next;
    logic                    olast_reg, olast_next;

    logic       accept;
    logic       out_free;
    req_t       req;
    status_t    req_status;
    store_ctl_t ctl;
    logic [IDX_W-1:0] ctl_idx;
    logic       full;
    logic       is_dump;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;

    logic [DEPTH-1:0][VALUE_WIDTH-1:0] entries;
    logic [VALUE_WIDTH-1:0] rd_word;
    logic signed [EXT_W-1:0] rd_ext;

    // output register frees up this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !dump_busy_reg && out_free;
    assign accept   = s_valid && s_ready;

    assign req     = req_t'(s_req_type);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign pos_cmp = CMP_W'(s_position);
    assign cnt_cmp = CMP_W'(count_reg);

    // request decode: status, store command and target index
    always_comb begin
        req_status = ST_DONE;
        ctl        = '0;
        ctl_idx    = '0;
        is_dump    = 1'b0;
        case (req)
            REQ_INS_FRONT: begin
                if (full) begin
                    req_status = ST_FULL;
                end else begin
                    ctl.ins_en = 1'b1;
                end
            end
            REQ_INS_BACK: begin
                if (full) begin
                    req_status = ST_FULL;
                end else begin
                    ctl.ins_en = 1'b1;
                    ctl_idx    = IDX_W'(count_reg);
                end
            end
            REQ_INS_POS: begin
                // position range is checked before fullness
                if (pos_cmp == '0 || pos_cmp > cnt_cmp + CMP_W'(1)) begin
                    req_status = ST_IGNORED;
                end else if (full) begin
                    req_status = ST_FULL;
                end else begin
                    ctl.ins_en = 1'b1;
                    ctl_idx    = IDX_W'(pos_cmp - CMP_W'(1));
                end
            end
            REQ_DEL_FRONT: begin
                if (count_reg == '0) begin
                    req_status = ST_IGNORED;
                end else begin
                    ctl.del_en = 1'b1;
                end
            end
            REQ_DEL_BACK: begin
                if (count_reg == '0) begin
                    req_status = ST_IGNORED;
                end else begin
                    ctl.del_en = 1'b1;
                    ctl_idx    = IDX_W'(count_reg - CNT_W'(1));
                end
            end
            REQ_DEL_POS: begin
                if (pos_cmp == '0 || pos_cmp > cnt_cmp) begin
                    req_status = ST_IGNORED;
                end else begin
                    ctl.del_en = 1'b1;
                    ctl_idx    = IDX_W'(pos_cmp - CMP_W'(1));
                end
            end
            REQ_DUMP: begin
                is_dump = 1'b1;
            end
            default: begin
                // unused request code
                req_status = ST_IGNORED;
            end
        endcase
        if (!accept) begin
            ctl = '0;
        end
    end

    plist_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .ctl      (ctl),
        .idx      (ctl_idx),
        .wr_value (VALUE_WIDTH'($unsigned(s_value))),
        .entries  (entries)
    );

    // dump read: front entry on the accepting beat, then the walking index
    assign rd_word = dump_busy_reg ? entries[dump_idx_reg] : entries[0];
    assign rd_ext  = EXT_W'(signed'(rd_word));

    // next state of count, dump walker and output register
    always_comb begin
        count_next     = count_reg;
        dump_busy_next = dump_busy_reg;
        dump_idx_next  = dump_idx_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        ocount_next    = ocount_reg;
        ovalue_next    = ovalue_reg;
        ovalid_next    = ovalid_reg;
        olast_next     = olast_reg;

        if (accept) begin
            if (ctl.ins_en) begin
                count_next = count_reg + CNT_W'(1);
            end else if (ctl.del_en) begin
                count_next = count_reg - CNT_W'(1);
            end
            m_valid_next = 1'b1;
            status_next  = req_status;
            ocount_next  = ctl.ins_en ? count_reg + CNT_W'(1) :
                           ctl.del_en ? count_reg - CNT_W'(1) : count_reg;
            ovalue_next  = '0;
            ovalid_next  = 1'b0;
            olast_next   = 1'b1;
            if (is_dump && count_reg != '0) begin
                ovalue_next = rd_ext[DATA_W-1:0];
                ovalid_next = 1'b1;
                if (count_reg != CNT_W'(1)) begin
                    olast_next     = 1'b0;
                    dump_busy_next = 1'b1;
                    dump_idx_next  = IDX_W'(1);
                end
            end
        end else if (dump_busy_reg && out_free) begin
            m_valid_next  = 1'b1;
            status_next   = ST_DONE;
            ocount_next   = count_reg;
            ovalue_next   = rd_ext[DATA_W-1:0];
            ovalid_next   = 1'b1;
            olast_next    = 1'b0;
            dump_idx_next = dump_idx_reg + IDX_W'(1);
            if (CNT_W'(dump_idx_reg) + CNT_W'(1) == count_reg) begin
                olast_next     = 1'b1;
                dump_busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dump_busy_reg <= 1'b0;
            dump_idx_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            dump_busy_reg <= dump_busy_next;
            dump_idx_reg  <= dump_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        ocount_reg <= ocount_next;
        ovalue_reg <= ovalue_next;
        ovalid_reg <= ovalid_next;
        olast_reg  <= olast_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_element_count = ocount_reg;
    assign m_item_value    = ovalue_reg;
    assign m_item_valid    = ovalid_reg;
    assign m_last          = olast_reg;

endmodule

// ----- tb/tb_positional_list_store_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for positional_list_store_top: directed, full-list and random tests
// depends on plist_pkg and the positional_list_store_top rtl
module tb_positional_list_store_top;
    import plist_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // request code outside the defined set
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

    // one result beat as the block should present it
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        logic [DATA_W-1:0]   item_value;
        logic                item_valid;
        logic                last;
    } list_beat_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type;
    logic signed [DATA_W-1:0] s_value;
    logic [POS_W-1:0]         s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic [STATUS_W-1:0]      m_status;
    logic [CNT_W-1:0]         m_element_count;
    logic signed [DATA_W-1:0] m_item_value;
    logic                     m_item_valid;
    logic                     m_last;

    // shadow copy of the list, updated as each request beat is taken
    logic [DATA_W-1:0] shadow_list [DEPTH];
    int                shadow_count;

    // result beats still owed by the block, oldest first
    list_beat_t beats_due [$];
    list_beat_t beat_want;

    int errors;
    bit src_gaps;       // sender draws random gaps between beats
    bit sink_gaps;      // receiver draws random stalls between beats
    int hold_left;      // long receiver hold-off, counted down by the receiver
    int wait_left;
    bit sink_took;

    positional_list_store_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_element_count (m_element_count),
        .m_item_value    (m_item_value),
        .m_item_valid    (m_item_valid),
        .m_last          (m_last)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // list predictor
    // ---------------------------------------------------------------

    function automatic void push_beat(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] v,
                                      logic vld, logic lst);
        list_beat_t b;
        b.status     = st;
        b.count      = shadow_count[CNT_W-1:0];
        b.item_value = v;
        b.item_valid = vld;
        b.last       = lst;
        beats_due.push_back(b);
    endfunction

    // open a slot at 0-based idx by shifting the tail up
    function automatic void shadow_insert(int idx, logic [DATA_W-1:0] v);
        int i;
        for (i = shadow_count; i > idx; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[idx] = v;
        shadow_count++;
    endfunction

    // close the slot at 0-based idx by shifting the tail down
    function automatic void shadow_remove(int idx);
        int i;
        for (i = idx; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i+1];
        shadow_count--;
    endfunction

    // apply one request to the shadow list and queue the beats it owes
    function automatic void predict_list_op(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val,
                                            logic [POS_W-1:0] pos);
        logic [STATUS_W-1:0] st;
        int i;
        st = ST_DONE;
        case (req)
            REQ_INS_FRONT: begin
                if (shadow_count >= DEPTH) st = ST_FULL;
                else shadow_insert(0, val);
            end
            REQ_INS_BACK: begin
                if (shadow_count >= DEPTH) st = ST_FULL;
                else shadow_insert(shadow_count, val);
            end
            REQ_INS_POS: begin
                // position range is checked ahead of fullness
                if (pos < 1 || pos > shadow_count + 1) st = ST_IGNORED;
                else if (shadow_count >= DEPTH) st = ST_FULL;
                else shadow_insert(pos - 1, val);
            end
            REQ_DEL_FRONT: begin
                if (shadow_count == 0) st = ST_IGNORED;
                else shadow_remove(0);
            end
            REQ_DEL_BACK: begin
                if (shadow_count == 0) st = ST_IGNORED;
                else shadow_remove(shadow_count - 1);
            end
            REQ_DEL_POS: begin
                if (pos < 1 || pos > shadow_count) st = ST_IGNORED;
                else shadow_remove(pos - 1);
            end
            REQ_DUMP: begin
                // an empty dump still gives one beat, with no element
                if (shadow_count == 0) begin
                    push_beat(ST_DONE, '0, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        push_beat(ST_DONE, shadow_list[i], 1'b1, i + 1 == shadow_count);
                end
                return;
            end
            default: st = ST_IGNORED;
        endcase
        push_beat(st, '0, 1'b0, 1'b1);
    endfunction

    // ---------------------------------------------------------------
    // request sender: one beat per call, returns at the accepting edge
    // ---------------------------------------------------------------

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        int  gap;
        bit  took;
        gap = src_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= val;
        s_position <= pos;
        // inputs only move at rising edges, so the falling edge shows the handshake
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        predict_list_op(req, val, pos);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // mostly a legal position up to hi, sometimes anything the field holds
    function automatic logic [POS_W-1:0] pick_position(int hi);
        if (hi < 1) return POS_W'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(1, hi));
        return POS_W'($urandom_range(0, 255));
    endfunction

    // ---------------------------------------------------------------
    // result receiver: draws a stall after every beat, obeys hold-off
    // ---------------------------------------------------------------

    initial begin
        m_ready   = 1'b0;
        wait_left = 0;
        forever begin
            @(negedge aclk);
            sink_took = (m_valid === 1'b1) && m_ready;
            @(posedge aclk);
            if (sink_took) wait_left = sink_gaps ? $urandom_range(0, 11) : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // result checker: every accepted beat against the oldest expectation
    // ---------------------------------------------------------------

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            if (beats_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h %h",
                         $time, m_status, m_item_value);
                errors++;
            end else begin
                beat_want = beats_due.pop_front();
                check_field("status", DATA_W'(beat_want.status), DATA_W'(m_status));
                check_field("element_count", DATA_W'(beat_want.count),
                            DATA_W'(m_element_count));
                check_field("item_value", beat_want.item_value, m_item_value);
                check_field("item_valid", DATA_W'(beat_want.item_valid),
                            DATA_W'(m_item_valid));
                check_field("last", DATA_W'(beat_want.last), DATA_W'(m_last));
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty-list cases, bad positions, value extremes, unknown code, small dumps
    task automatic test_directed_cases();
        src_gaps  = 1;
        sink_gaps = 1;
        send_req(REQ_DUMP, '0, '0);                     // dump of empty list
        send_req(REQ_DEL_FRONT, '0, '0);                // deletes from empty list
        send_req(REQ_DEL_BACK, '1, 8'd1);
        send_req(REQ_DEL_POS, '0, 8'd1);
        send_req(REQ_DEL_POS, '0, 8'd0);
        send_req(REQ_INS_POS, 32'h1234_5678, 8'd0);     // position zero
        send_req(REQ_INS_POS, 32'h1234_5678, 8'd2);     // one past count + 1
        send_req(REQ_INS_POS, '1, 8'd255);
        send_req(REQ_UNKNOWN, '1, 8'd255);              // unknown request code
        send_req(REQ_INS_POS, 32'h7fff_ffff, 8'd1);     // insert at position one of empty list
        send_req(REQ_INS_FRONT, 32'h8000_0000, 8'd0);
        send_req(REQ_INS_BACK, 32'hffff_ffff, 8'd255);
        send_req(REQ_INS_BACK, 32'h0000_0000, 8'd0);
        send_req(REQ_INS_POS, 32'ha5a5_a5a5, 8'd3);     // middle insert
        send_req(REQ_INS_POS, 32'h5a5a_5a5a, 8'd6);     // insert at count + 1
        send_req(REQ_DUMP, '1, 8'd255);
        send_req(REQ_DEL_POS, '0, 8'd4);
        send_req(REQ_DEL_POS, '0, 8'd6);                // past count
        send_req(REQ_DEL_POS, '0, 8'd255);
        send_req(REQ_DEL_FRONT, '0, '0);
        send_req(REQ_DEL_BACK, '0, '0);
        send_req(REQ_DUMP, '0, '0);
        send_req(REQ_UNKNOWN, '0, '0);
        send_req(REQ_DUMP, '0, '0);
    endtask

    // fill to depth under a long receiver hold-off, then hit every full-list case
    task automatic test_full_list();
        int kind;
        src_gaps  = 0;
        sink_gaps = 1;
        // receiver stops for a long stretch; the sender keeps offering beats
        hold_left = 120;
        while (shadow_count < DEPTH) begin
            kind = $urandom_range(0, 2);
            case (kind)
                0: send_req(REQ_INS_FRONT, pick_value(), POS_W'($urandom()));
                1: send_req(REQ_INS_BACK, pick_value(), POS_W'($urandom()));
                default: send_req(REQ_INS_POS, pick_value(), pick_position(shadow_count + 1));
            endcase
        end
        src_gaps = 1;
        send_req(REQ_INS_FRONT, 32'hdead_beef, '0);     // full rejects
        send_req(REQ_INS_BACK, 32'hdead_beef, '0);
        send_req(REQ_INS_POS, 32'hdead_beef, 8'd1);
        send_req(REQ_INS_POS, 32'hdead_beef, POS_W'(DEPTH + 1));
        // bad position wins over full
        send_req(REQ_INS_POS, 32'hdead_beef, POS_W'(DEPTH + 2));
        send_req(REQ_INS_POS, 32'hdead_beef, 8'd0);
        send_req(REQ_DUMP, '0, '0);                     // longest dump
        send_req(REQ_DEL_POS, '0, POS_W'(DEPTH + 1));
        send_req(REQ_DEL_POS, '0, POS_W'(DEPTH));
        send_req(REQ_DEL_BACK, '0, '0);
        send_req(REQ_DEL_FRONT, '0, '0);
        send_req(REQ_DUMP, '0, '0);
    endtask

    // mostly legal requests with a drifting grow/shrink bias, some noise
    task automatic test_random_mix(input int n_items);
        int n, r, kind;
        bit grow, ins;
        logic [REQ_W-1:0]  req;
        logic [POS_W-1:0]  pos;
        grow = 1;
        for (n = 0; n < n_items; n++) begin
            // rotate idling patterns, including stretches with none
            if (n % 40 == 0) begin
                case ((n / 40) % 4)
                    0: begin src_gaps = 1; sink_gaps = 1; end
                    1: begin src_gaps = 0; sink_gaps = 0; end
                    2: begin src_gaps = 1; sink_gaps = 0; end
                    default: begin src_gaps = 0; sink_gaps = 1; end
                endcase
            end
            if ($urandom_range(0, 29) == 0) grow = !grow;
            if (shadow_count <= 1) grow = 1;
            else if (shadow_count == DEPTH && $urandom_range(0, 1) == 0) grow = 0;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                req = REQ_DUMP;
                pos = POS_W'($urandom());
            end else if (r < 14) begin
                req = REQ_W'($urandom_range(0, 7));
                pos = POS_W'($urandom_range(0, 255));
            end else begin
                ins  = grow ? (r < 70) : (r < 40);
                kind = $urandom_range(0, 2);
                if (ins) begin
                    req = (kind == 0) ? REQ_INS_FRONT : (kind == 1) ? REQ_INS_BACK : REQ_INS_POS;
                    pos = pick_position(shadow_count + 1);
                end else begin
                    req = (kind == 0) ? REQ_DEL_FRONT : (kind == 1) ? REQ_DEL_BACK : REQ_DEL_POS;
                    pos = pick_position(shadow_count);
                end
            end
            send_req(req, pick_value(), pos);
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = '0;
        s_value      = '0;
        s_position   = '0;
        src_gaps     = 1;
        sink_gaps    = 1;
        hold_left    = 0;
        shadow_count = 0;
        errors       = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_list();
        test_random_mix(170);
        s_valid <= 1'b0;

        // drain, then wait on to catch stray beats
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (errors == 0 && beats_due.size() == 0) begin
            $display("tb_positional_list_store_top passed");
        end else begin
            $display("tb_positional_list_store_top failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_positional_list_store_top failed");
        $finish;
    end

endmodule
